@@ rtl/core/cps_pkg.sv @@
// ----------------------------------------------------------------------------
// cps_pkg
// Widths, register indexes and helpers for the closest point on slab block.
// ----------------------------------------------------------------------------
package cps_pkg;

  localparam int COORD_W  = 20;
  localparam int UNIT_W   = 16;
  localparam int FRAC     = 14;
  localparam int EXT_W    = 19;
  localparam int ORIGIN_W = 3 * COORD_W;
  localparam int VEC_W    = 3 * UNIT_W;
  localparam int CFG_W    = ORIGIN_W;
  localparam int IDX_W    = 3;

  localparam int D_W    = COORD_W + 1;
  localparam int DN_W   = D_W + UNIT_W;
  localparam int DS_W   = DN_W + 2;
  localparam int DIST_W = DS_W - FRAC;
  localparam int PN_W   = DIST_W + UNIT_W;
  localparam int Q_W    = PN_W - FRAC + 1;
  localparam int R_W    = Q_W + 1;
  localparam int CP_W   = 2 * UNIT_W + 1;
  localparam int C_W    = CP_W - FRAC;
  localparam int RA_W   = R_W + UNIT_W;
  localparam int RC_W   = R_W + C_W;
  localparam int RAS_W  = RA_W + 2;
  localparam int RCS_W  = RC_W + 2;
  localparam int U_W    = RAS_W - FRAC;
  localparam int V_W    = RCS_W - FRAC;
  localparam int AU_W   = U_W + 1;
  localparam int AV_W   = V_W + 1;
  localparam int AUA_W  = AU_W + UNIT_W;
  localparam int AVC_W  = AV_W + C_W;
  localparam int F_W    = AVC_W - FRAC + 2;

  localparam int LATENCY = 9;

  localparam int COORD_MAX = 524287;
  localparam int COORD_MIN = -524288;

  localparam logic [IDX_W-1:0] REG_SLAB_MODE  = 3'd0;
  localparam logic [IDX_W-1:0] REG_ORIGIN     = 3'd1;
  localparam logic [IDX_W-1:0] REG_NORMAL     = 3'd2;
  localparam logic [IDX_W-1:0] REG_AXIS       = 3'd3;
  localparam logic [IDX_W-1:0] REG_EXT_ALONG  = 3'd4;
  localparam logic [IDX_W-1:0] REG_EXT_ACROSS = 3'd5;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [UNIT_W-1:0]  unit_t;

  function automatic coord_t sat_coord(input logic signed [F_W-1:0] v);
    coord_t res;
    if (v > F_W'(COORD_MAX)) begin
      res = COORD_W'(COORD_MAX);
    end else if (v < F_W'(COORD_MIN)) begin
      res = COORD_W'(COORD_MIN);
    end else begin
      res = v[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage

@@ rtl/core/closest_point_on_slab_top.sv @@
// ----------------------------------------------------------------------------
// closest_point_on_slab_top
// Nearest point on a configured plane or clamped rectangular slab.
// ----------------------------------------------------------------------------
// One query word is taken in every cycle (busy stays low); its result appears
// on near_x/y/z with done high for one cycle. The nine-stage pipeline puts a
// register after every multiplier bank and every wide sum. The receiver cannot
// stall, so no word is ever held back. The user must write configuration only
// with the pipeline empty; the block itself does not enforce this.
module closest_point_on_slab_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [cps_pkg::COORD_W-1:0]  point_x,
  input  logic signed [cps_pkg::COORD_W-1:0]  point_y,
  input  logic signed [cps_pkg::COORD_W-1:0]  point_z,
  output logic                                done,
  output logic signed [cps_pkg::COORD_W-1:0]  near_x,
  output logic signed [cps_pkg::COORD_W-1:0]  near_y,
  output logic signed [cps_pkg::COORD_W-1:0]  near_z,
  input  logic                                cfg_wr_en,
  input  logic [cps_pkg::IDX_W-1:0]           cfg_index,
  input  logic [cps_pkg::CFG_W-1:0]           cfg_wdata
);

  localparam int COORD_W = cps_pkg::COORD_W;
  localparam int UNIT_W  = cps_pkg::UNIT_W;
  localparam int FRAC    = cps_pkg::FRAC;
  localparam int EXT_W   = cps_pkg::EXT_W;
  localparam int DN_W    = cps_pkg::DN_W;
  localparam int DS_W    = cps_pkg::DS_W;
  localparam int DIST_W  = cps_pkg::DIST_W;
  localparam int PN_W    = cps_pkg::PN_W;
  localparam int Q_W     = cps_pkg::Q_W;
  localparam int R_W     = cps_pkg::R_W;
  localparam int CP_W    = cps_pkg::CP_W;
  localparam int C_W     = cps_pkg::C_W;
  localparam int RA_W    = cps_pkg::RA_W;
  localparam int RC_W    = cps_pkg::RC_W;
  localparam int RAS_W   = cps_pkg::RAS_W;
  localparam int RCS_W   = cps_pkg::RCS_W;
  localparam int U_W     = cps_pkg::U_W;
  localparam int V_W     = cps_pkg::V_W;
  localparam int AU_W    = cps_pkg::AU_W;
  localparam int AV_W    = cps_pkg::AV_W;
  localparam int AUA_W   = cps_pkg::AUA_W;
  localparam int AVC_W   = cps_pkg::AVC_W;
  localparam int F_W     = cps_pkg::F_W;

  // configuration registers
  logic                          slab_mode;
  logic [cps_pkg::ORIGIN_W-1:0]  origin_packed;
  logic [cps_pkg::VEC_W-1:0]     normal_packed;
  logic [cps_pkg::VEC_W-1:0]     axis_packed;
  logic [EXT_W-1:0]              extent_along_axis;
  logic [EXT_W-1:0]              extent_across_axis;

  always_ff @(posedge clk) begin
    if (rst) begin
      slab_mode          <= 1'b0;
      origin_packed      <= '0;
      normal_packed      <= '0;
      axis_packed        <= '0;
      extent_along_axis  <= '0;
      extent_across_axis <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cps_pkg::REG_SLAB_MODE:  slab_mode          <= cfg_wdata[0];
        cps_pkg::REG_ORIGIN:     origin_packed      <= cfg_wdata[cps_pkg::ORIGIN_W-1:0];
        cps_pkg::REG_NORMAL:     normal_packed      <= cfg_wdata[cps_pkg::VEC_W-1:0];
        cps_pkg::REG_AXIS:       axis_packed        <= cfg_wdata[cps_pkg::VEC_W-1:0];
        cps_pkg::REG_EXT_ALONG:  extent_along_axis  <= cfg_wdata[EXT_W-1:0];
        cps_pkg::REG_EXT_ACROSS: extent_across_axis <= cfg_wdata[EXT_W-1:0];
        default: ;
      endcase
    end
  end

  cps_pkg::coord_t org [3];
  cps_pkg::unit_t  nrm [3];
  cps_pkg::unit_t  axs [3];
  cps_pkg::coord_t pin [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      org[i] = origin_packed[COORD_W*i +: COORD_W];
      nrm[i] = normal_packed[UNIT_W*i +: UNIT_W];
      axs[i] = axis_packed[UNIT_W*i +: UNIT_W];
    end
    pin[0] = point_x;
    pin[1] = point_y;
    pin[2] = point_z;
  end

  // cross axis c = n x a, follows the config registers
  logic signed [C_W-1:0] crs [3];

  always_ff @(posedge clk) begin
    crs[0] <= C_W'((CP_W'(nrm[1]) * CP_W'(axs[2]) - CP_W'(nrm[2]) * CP_W'(axs[1])) >>> FRAC);
    crs[1] <= C_W'((CP_W'(nrm[2]) * CP_W'(axs[0]) - CP_W'(nrm[0]) * CP_W'(axs[2])) >>> FRAC);
    crs[2] <= C_W'((CP_W'(nrm[0]) * CP_W'(axs[1]) - CP_W'(nrm[1]) * CP_W'(axs[0])) >>> FRAC);
  end

  logic signed [EXT_W:0] lim_u;
  logic signed [EXT_W:0] lim_v;

  assign lim_u = $signed({1'b0, extent_along_axis});
  assign lim_v = $signed({1'b0, extent_across_axis});

  // valid bits
  logic [cps_pkg::LATENCY-2:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[cps_pkg::LATENCY-3:0], start & ~busy};
      done <= vld[cps_pkg::LATENCY-2];
    end
  end

  assign busy = 1'b0;

  // pipeline payload
  logic signed [DN_W-1:0]   dn  [3];
  cps_pkg::coord_t          p1  [3];
  logic signed [DIST_W-1:0] plane_off;
  cps_pkg::coord_t          p2  [3];
  logic signed [PN_W-1:0]   pn  [3];
  cps_pkg::coord_t          p3  [3];
  logic signed [Q_W-1:0]    q_next [3];
  logic signed [Q_W-1:0]    q4  [3];
  logic signed [R_W-1:0]    r4  [3];
  logic signed [RA_W-1:0]   ra  [3];
  logic signed [RC_W-1:0]   rc  [3];
  logic signed [Q_W-1:0]    q5  [3];
  logic signed [U_W-1:0]    u6;
  logic signed [V_W-1:0]    v6;
  logic signed [Q_W-1:0]    q6  [3];
  logic signed [AU_W-1:0]   au7;
  logic signed [AV_W-1:0]   av7;
  logic signed [Q_W-1:0]    q7  [3];
  logic signed [AUA_W-1:0]  pa  [3];
  logic signed [AVC_W-1:0]  pc  [3];
  logic signed [Q_W-1:0]    q8  [3];
  logic signed [F_W-1:0]    f_next [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_next[i] = Q_W'(p3[i]) + Q_W'(pn[i] >>> FRAC);
      if (slab_mode) begin
        f_next[i] = F_W'(q8[i]) - F_W'(pa[i] >>> FRAC) - F_W'(pc[i] >>> FRAC);
      end else begin
        f_next[i] = F_W'(q8[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dn[i] <= (DN_W'(org[i]) - DN_W'(pin[i])) * DN_W'(nrm[i]);
      p1[i] <= pin[i];
      p2[i] <= p1[i];
      pn[i] <= PN_W'(plane_off) * PN_W'(nrm[i]);
      p3[i] <= p2[i];
      q4[i] <= q_next[i];
      r4[i] <= R_W'(q_next[i]) - R_W'(org[i]);
      ra[i] <= RA_W'(r4[i]) * RA_W'(axs[i]);
      rc[i] <= RC_W'(r4[i]) * RC_W'(crs[i]);
      q5[i] <= q4[i];
      q6[i] <= q5[i];
      q7[i] <= q6[i];
      pa[i] <= AUA_W'(au7) * AUA_W'(axs[i]);
      pc[i] <= AVC_W'(av7) * AVC_W'(crs[i]);
      q8[i] <= q7[i];
    end
    plane_off <= DIST_W'((DS_W'(dn[0]) + DS_W'(dn[1]) + DS_W'(dn[2])) >>> FRAC);
    u6   <= U_W'((RAS_W'(ra[0]) + RAS_W'(ra[1]) + RAS_W'(ra[2])) >>> FRAC);
    v6   <= V_W'((RCS_W'(rc[0]) + RCS_W'(rc[1]) + RCS_W'(rc[2])) >>> FRAC);
    if (u6 > U_W'(lim_u)) begin
      au7 <= AU_W'(u6) - AU_W'(lim_u);
    end else if (u6[U_W-1]) begin
      au7 <= AU_W'(u6);
    end else begin
      au7 <= '0;
    end
    if (v6 > V_W'(lim_v)) begin
      av7 <= AV_W'(v6) - AV_W'(lim_v);
    end else if (v6[V_W-1]) begin
      av7 <= AV_W'(v6);
    end else begin
      av7 <= '0;
    end
    near_x <= cps_pkg::sat_coord(f_next[0]);
    near_y <= cps_pkg::sat_coord(f_next[1]);
    near_z <= cps_pkg::sat_coord(f_next[2]);
  end

`ifndef ASSERT_OFF
  a_word_out: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(cps_pkg::LATENCY) done)
    else $error("accepted word produced no result");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, cps_pkg::LATENCY))
    else $error("result without accepted word");

  a_plane_clamp: assert property (@(posedge clk) disable iff (rst)
    (!slab_mode && vld[cps_pkg::LATENCY-2])
      |=> (near_x == $past(cps_pkg::sat_coord(F_W'(q8[0])))))
    else $error("plane mode result altered by clamp");
`endif

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the closest point on slab block.
// A short directed table covers reset values, coordinate extremes, plane and
// slab geometry, clamping on both sides, saturation, ignored register bits and
// unused register indexes. Random phases follow, each with a fresh register
// setting and random query words. Every result word is compared with a typed
// table expectation or else a local fixed-point model of projection and clamp.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W   = cps_pkg::COORD_W;
  localparam int UNIT_W    = cps_pkg::UNIT_W;
  localparam int FRAC      = cps_pkg::FRAC;
  localparam int EXT_W     = cps_pkg::EXT_W;
  localparam int ORIGIN_W  = cps_pkg::ORIGIN_W;
  localparam int VEC_W     = cps_pkg::VEC_W;
  localparam int CFG_W     = cps_pkg::CFG_W;
  localparam int IDX_W     = cps_pkg::IDX_W;
  localparam int COORD_MAX = cps_pkg::COORD_MAX;
  localparam int COORD_MIN = cps_pkg::COORD_MIN;

  typedef cps_pkg::coord_t coord_t;
  typedef cps_pkg::unit_t  unit_t;

  localparam int PHASES       = 19;
  localparam int PHASE_WORDS  = 100;
  localparam int DRAIN_CYCLES = cps_pkg::LATENCY + 3;
  localparam logic [IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam unit_t UNIT_ONE = 16'sd16384;
  localparam logic [CFG_W-1:0] ALL_ONES = {CFG_W{1'b1}};

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } near_t;

  typedef enum logic {ROW_WRITE, ROW_POINT} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    logic [IDX_W-1:0] idx;
    logic [CFG_W-1:0] data;
    coord_t           x;
    coord_t           y;
    coord_t           z;
    bit               has_want;
    near_t            want;
  } row_t;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  coord_t           point_x;
  coord_t           point_y;
  coord_t           point_z;
  logic             done;
  coord_t           near_x;
  coord_t           near_y;
  coord_t           near_z;
  logic             cfg_wr_en;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  // typed expectation that travels with the current query word
  logic  has_want;
  near_t want_near;

  // local copy of the register file
  logic                slab_reg;
  logic [ORIGIN_W-1:0] origin_reg;
  logic [VEC_W-1:0]    normal_reg;
  logic [VEC_W-1:0]    axis_reg;
  logic [EXT_W-1:0]    ext_along_reg;
  logic [EXT_W-1:0]    ext_across_reg;

  near_t expected_near[$];
  row_t  directed_rows[$];
  int    fail_count;
  int    words_sent;
  int    slab_words;
  int    results_seen;
  int    settings_used;

  closest_point_on_slab_top u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .done       (done),
    .near_x     (near_x),
    .near_y     (near_y),
    .near_z     (near_z),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

  function automatic longint drop_frac(longint v);
    return v >>> FRAC;
  endfunction

  function automatic coord_t clip_coord(longint v);
    if (v > COORD_MAX) begin
      return coord_t'(COORD_MAX);
    end
    if (v < COORD_MIN) begin
      return coord_t'(COORD_MIN);
    end
    return coord_t'(v);
  endfunction

  function automatic near_t nearest_on_obstacle(coord_t px, coord_t py, coord_t pz);
    longint p[3], o[3], n[3], a[3], c[3], q[3], r[3];
    longint plane_off, u, v, pull_u, pull_v, lim_u, lim_v;
    near_t  res;
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    for (int i = 0; i < 3; i++) begin
      o[i] = longint'($signed(origin_reg[COORD_W*i +: COORD_W]));
      n[i] = longint'($signed(normal_reg[UNIT_W*i +: UNIT_W]));
      a[i] = longint'($signed(axis_reg[UNIT_W*i +: UNIT_W]));
    end
    plane_off = drop_frac((o[0] - p[0]) * n[0] + (o[1] - p[1]) * n[1] +
                          (o[2] - p[2]) * n[2]);
    for (int i = 0; i < 3; i++) begin
      q[i] = p[i] + drop_frac(plane_off * n[i]);
    end
    if (slab_reg) begin
      c[0] = drop_frac(n[1] * a[2] - n[2] * a[1]);
      c[1] = drop_frac(n[2] * a[0] - n[0] * a[2]);
      c[2] = drop_frac(n[0] * a[1] - n[1] * a[0]);
      for (int i = 0; i < 3; i++) begin
        r[i] = q[i] - o[i];
      end
      u = drop_frac(r[0] * a[0] + r[1] * a[1] + r[2] * a[2]);
      v = drop_frac(r[0] * c[0] + r[1] * c[1] + r[2] * c[2]);
      lim_u = ext_along_reg;
      lim_v = ext_across_reg;
      pull_u = (u > lim_u) ? u - lim_u : ((u < 0) ? u : 0);
      pull_v = (v > lim_v) ? v - lim_v : ((v < 0) ? v : 0);
      for (int i = 0; i < 3; i++) begin
        q[i] = q[i] - drop_frac(pull_u * a[i]) - drop_frac(pull_v * c[i]);
      end
    end
    res.x = clip_coord(q[0]);
    res.y = clip_coord(q[1]);
    res.z = clip_coord(q[2]);
    return res;
  endfunction

  task automatic report_field(string name, coord_t want, coord_t got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    near_t want;
    if (!rst) begin
      if (done) begin
        results_seen++;
        if (expected_near.size() == 0) begin
          $display("%0t: unexpected result word (%0d, %0d, %0d)", $time, near_x, near_y,
                   near_z);
          fail_count++;
        end else begin
          want = expected_near.pop_front();
          report_field("near_x", want.x, near_x);
          report_field("near_y", want.y, near_y);
          report_field("near_z", want.z, near_z);
        end
      end
      if (start && !busy) begin
        words_sent++;
        if (slab_reg) begin
          slab_words++;
        end
        if (has_want) begin
          expected_near.push_back(want_near);
        end else begin
          expected_near.push_back(nearest_on_obstacle(point_x, point_y, point_z));
        end
      end
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    start     = 1'b0;
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    case (idx)
      cps_pkg::REG_SLAB_MODE:  slab_reg       = data[0];
      cps_pkg::REG_ORIGIN:     origin_reg     = data[ORIGIN_W-1:0];
      cps_pkg::REG_NORMAL:     normal_reg     = data[VEC_W-1:0];
      cps_pkg::REG_AXIS:       axis_reg       = data[VEC_W-1:0];
      cps_pkg::REG_EXT_ALONG:  ext_along_reg  = data[EXT_W-1:0];
      cps_pkg::REG_EXT_ACROSS: ext_across_reg = data[EXT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic send_point(coord_t x, coord_t y, coord_t z, bit typed, near_t want,
                            int gap);
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start     = 1'b1;
    point_x   = x;
    point_y   = y;
    point_z   = z;
    has_want  = typed;
    want_near = want;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    @(negedge clk);
    start    = 1'b0;
    has_want = 1'b0;
    while (expected_near.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    row_t row;
    row = '{kind: ROW_WRITE, idx: idx, data: data, x: '0, y: '0, z: '0,
            has_want: 1'b0, want: '0};
    directed_rows.push_back(row);
  endtask

  task automatic add_point(coord_t x, coord_t y, coord_t z, bit typed = 1'b0,
                           coord_t wx = '0, coord_t wy = '0, coord_t wz = '0);
    row_t row;
    row = '{kind: ROW_POINT, idx: '0, data: '0, x: x, y: y, z: z,
            has_want: typed, want: '{x: wx, y: wy, z: wz}};
    directed_rows.push_back(row);
  endtask

  function automatic logic [CFG_W-1:0] with_junk(logic [CFG_W-1:0] v, int w);
    logic [CFG_W-1:0] mask;
    logic [CFG_W-1:0] junk;
    mask = (CFG_W'(1) << w) - CFG_W'(1);
    junk = CFG_W'({$urandom, $urandom});
    if ($urandom_range(0, 1)) begin
      return (v & mask) | (junk & ~mask);
    end
    return v & mask;
  endfunction

  function automatic unit_t pick_unit();
    case ($urandom_range(0, 5))
      0: return unit_t'($urandom);
      1: return unit_t'($urandom_range(0, 32768) - 16384);
      2: return '0;
      3: return unit_t'(16'h8000);
      4: return unit_t'(16'h7fff);
      default: return $urandom_range(0, 1) ? UNIT_ONE : -UNIT_ONE;
    endcase
  endfunction

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 4))
      0: return coord_t'($urandom);
      1: return coord_t'(COORD_MIN);
      2: return coord_t'(COORD_MAX);
      3: return '0;
      default: return coord_t'($urandom_range(0, 8191) - 4096);
    endcase
  endfunction

  function automatic logic [EXT_W-1:0] pick_ext();
    case ($urandom_range(0, 4))
      0: return EXT_W'($urandom);
      1: return EXT_W'($urandom_range(0, 8192));
      2: return '0;
      3: return {EXT_W{1'b1}};
      default: return EXT_W'($urandom_range(0, 2048));
    endcase
  endfunction

  function automatic logic [VEC_W-1:0] unit_axis(int k, bit neg);
    logic [VEC_W-1:0] vec;
    vec = '0;
    vec[UNIT_W*k +: UNIT_W] = neg ? -UNIT_ONE : UNIT_ONE;
    return vec;
  endfunction

  task automatic random_setup();
    logic [VEC_W-1:0] nv;
    logic [VEC_W-1:0] av;
    int               k;
    bit               axial;
    axial = ($urandom_range(0, 2) != 0);
    k     = $urandom_range(0, 2);
    nv    = axial ? unit_axis(k, 1'($urandom_range(0, 1)))
                  : {pick_unit(), pick_unit(), pick_unit()};
    if (axial && $urandom_range(0, 3) != 0) begin
      av = unit_axis((k + 1 + $urandom_range(0, 1)) % 3, 1'($urandom_range(0, 1)));
    end else begin
      av = {pick_unit(), pick_unit(), pick_unit()};
    end
    write_reg(cps_pkg::REG_SLAB_MODE, with_junk(CFG_W'($urandom_range(0, 1)), 1));
    write_reg(cps_pkg::REG_ORIGIN,
              with_junk({pick_coord(), pick_coord(), pick_coord()}, ORIGIN_W));
    write_reg(cps_pkg::REG_NORMAL, with_junk(CFG_W'(nv), VEC_W));
    write_reg(cps_pkg::REG_AXIS, with_junk(CFG_W'(av), VEC_W));
    write_reg(cps_pkg::REG_EXT_ALONG, with_junk(CFG_W'(pick_ext()), EXT_W));
    write_reg(cps_pkg::REG_EXT_ACROSS, with_junk(CFG_W'(pick_ext()), EXT_W));
    if ($urandom_range(0, 3) == 0) begin
      write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7,
                CFG_W'({$urandom, $urandom}));
    end
    settings_used++;
  endtask

  task automatic random_point(output coord_t x, output coord_t y, output coord_t z);
    case ($urandom_range(0, 3))
      0: begin
        x = coord_t'($urandom);
        y = coord_t'($urandom);
        z = coord_t'($urandom);
      end
      3: begin
        x = pick_coord();
        y = pick_coord();
        z = pick_coord();
      end
      default: begin
        x = coord_t'(origin_reg[0 +: COORD_W] + $urandom_range(0, 8191) - 4096);
        y = coord_t'(origin_reg[COORD_W +: COORD_W] + $urandom_range(0, 8191) - 4096);
        z = coord_t'(origin_reg[2*COORD_W +: COORD_W] + $urandom_range(0, 8191) - 4096);
      end
    endcase
  endtask

  initial begin
    coord_t mx;
    coord_t mn;
    coord_t x;
    coord_t y;
    coord_t z;
    bit     pending;
    bit     steady;
    mx = coord_t'(COORD_MAX);
    mn = coord_t'(COORD_MIN);
    rst            = 1'b1;
    start          = 1'b0;
    point_x        = '0;
    point_y        = '0;
    point_z        = '0;
    cfg_wr_en      = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    has_want       = 1'b0;
    want_near      = '0;
    slab_reg       = 1'b0;
    origin_reg     = '0;
    normal_reg     = '0;
    axis_reg       = '0;
    ext_along_reg  = '0;
    ext_across_reg = '0;
    fail_count     = 0;
    words_sent     = 0;
    slab_words     = 0;
    results_seen   = 0;
    settings_used  = 1;

    // reset registers: zero normal, projection is the identity
    add_point(0, 0, 0, 1, 0, 0, 0);
    add_point(mx, mx, mx, 1, mx, mx, mx);
    add_point(mn, mn, mn, 1, mn, mn, mn);
    add_point(mx, mn, -1, 1, mx, mn, -1);
    // plane z = 0, then z = 100
    add_write(cps_pkg::REG_NORMAL, CFG_W'(48'h4000_0000_0000));
    add_point(mx, mn, mx, 1, mx, mn, 0);
    add_point(1234, -5, -777, 1, 1234, -5, 0);
    add_write(cps_pkg::REG_ORIGIN, CFG_W'(100) << (2 * COORD_W));
    add_point(3, 4, -9, 1, 3, 4, 100);
    // slab along x, across y; upper bits of the mode word ignored
    add_write(cps_pkg::REG_SLAB_MODE, ALL_ONES);
    add_write(cps_pkg::REG_AXIS, CFG_W'(48'h0000_0000_4000));
    add_write(cps_pkg::REG_EXT_ALONG, CFG_W'(1024));
    add_write(cps_pkg::REG_EXT_ACROSS, CFG_W'(2048));
    add_point(5000, -3000, 777, 1, 1024, 0, 100);
    add_point(512, 1024, -5, 1, 512, 1024, 100);
    add_write(cps_pkg::REG_EXT_ALONG, ALL_ONES);
    add_write(cps_pkg::REG_EXT_ACROSS, CFG_W'(0));
    add_point(mx, mx, 0, 1, mx, 0, 100);
    add_write(REG_SPARE_6, ALL_ONES);
    add_write(REG_SPARE_7, ALL_ONES);
    add_point(-7, mn, 3);
    // non-unit extreme vectors, saturating outputs
    add_write(cps_pkg::REG_NORMAL, CFG_W'(48'h8000_8000_8000));
    add_write(cps_pkg::REG_AXIS, CFG_W'(48'h7fff_7fff_7fff));
    add_write(cps_pkg::REG_ORIGIN, ALL_ONES);
    add_point(mx, mx, mx);
    add_point(mn, mn, mn);
    add_point(mx, mn, 0);
    // degenerate axis
    add_write(cps_pkg::REG_AXIS, CFG_W'(0));
    add_point(1000, 2000, 3000);
    add_point(mn, mx, -1);
    // plane mode with a non-unit normal
    add_write(cps_pkg::REG_SLAB_MODE, CFG_W'(0));
    add_point(-100, 200, mx);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    pending = 1'b0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        if (pending) begin
          drain();
          settings_used++;
        end
        pending = 1'b0;
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                   directed_rows[i].has_want, directed_rows[i].want, $urandom_range(0, 4));
        pending = 1'b1;
      end
    end
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      random_setup();
      steady = ($urandom_range(0, 3) == 0);
      for (int w = 0; w < PHASE_WORDS; w++) begin
        random_point(x, y, z);
        send_point(x, y, z, 1'b0, '0, steady ? 0 : $urandom_range(0, 4));
      end
      drain();
    end

    $display("summary: %0d query words, %0d in slab mode, over %0d register settings",
             words_sent, slab_words, settings_used);
    $display("summary: %0d result words compared, %0d mismatches", results_seen, fail_count);
    if (fail_count == 0 && expected_near.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/cps_pkg.sv
rtl/core/closest_point_on_slab_top.sv
tb/tb_top.sv
